### rtl/ncdf_pkg.sv
// Package for the normal CDF pipeline: widths, Q.28 constants and helpers.
// Used by all modules of the normal_cdf_approximation block.
`default_nettype none
package ncdf_pkg;
  localparam int IN_FRAC_BITS = 16;
  localparam int OUT_FRAC_BITS = 16;
  localparam int X_W = 20;
  localparam int P_W = OUT_FRAC_BITS + 1;
  localparam int FQ = 28;
  localparam int QW = 32;

  localparam logic [QW-1:0] ONE = 32'd268435456;
  localparam logic [QW-1:0] ZMAX = 32'd2147483648;
  localparam logic signed [QW:0] K_A1 = 33'sd68405298;
  localparam logic signed [QW:0] K_A2 = -33'sd76369011;
  localparam logic signed [QW:0] K_A3 = 33'sd381557846;
  localparam logic signed [QW:0] K_A4 = -33'sd390077527;
  localparam logic signed [QW:0] K_A5 = 33'sd284918850;
  localparam logic [QW-1:0] K_P = 32'd87937066;
  localparam logic [QW-1:0] K_INVSQRT2 = 32'd189812531;
  localparam logic [QW-1:0] K_LN2 = 32'd186065280;

  // Rounded unsigned Q.28 product.
  function automatic logic [QW+7:0] umulq(input logic [QW+7:0] a, input logic [QW+7:0] b);
    logic [2*QW+15:0] p;
    p = {{(QW+8){1'b0}}, a} * {{(QW+8){1'b0}}, b} + (64'd1 << (FQ - 1));
    return p[FQ +: QW+8];
  endfunction

  // Symmetric rounded signed by unsigned product.
  function automatic logic signed [QW:0] smulq(input logic signed [QW:0] a,
                                              input logic [QW-1:0] b);
    logic [QW+7:0] m;
    logic [QW+7:0] p;
    m = a[QW] ? (QW+8)'(-a) : (QW+8)'(a);
    p = umulq(m, {8'd0, b});
    return a[QW] ? -(QW+1)'(p) : (QW+1)'(p);
  endfunction
endpackage
`default_nettype wire

### rtl/ncdf_div.sv
// Pipelined restoring divider: t = round(2^56 / d), one quotient bit per stage.
// Depends on ncdf_pkg.
`default_nettype none
module ncdf_div import ncdf_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic [QW+1:0] d,
  input  wire logic [QW+7:0] side_in,
  output logic               out_valid,
  output logic [QW:0]        t,
  output logic [QW+7:0]      side_out
);
  // quotient <= 2^28, so 30 bits of quotient cover it; divide (2^56 + d/2) by d
  localparam int NB = 30;
  logic            vld  [NB+1];
  logic [QW+2:0]   rem  [NB+1];
  logic [NB-1:0]   quo  [NB+1];
  logic [QW+1:0]   dv   [NB+1];
  logic [QW+7:0]   sd   [NB+1];

  // stage 0: numerator split into high part and bits still to shift in
  always_ff @(posedge clk) begin
    logic [2*FQ:0] num;
    num = (57'd1 << (2 * FQ)) + 57'(d >> 1);
    if (rst) vld[0] <= 1'b0;
    else vld[0] <= in_valid;
    rem[0] <= (QW+3)'(num >> NB);
    dv[0]  <= d;
    sd[0]  <= side_in;
    quo[0] <= NB'(num[NB-1:0]);
  end

  // one quotient bit per stage; quo shifts numerator bits out and quotient in
  for (genvar i = 0; i < NB; i++) begin : g_st
    always_ff @(posedge clk) begin
      logic [QW+3:0] r2;
      r2 = {rem[i], quo[i][NB-1]};
      if (rst) vld[i+1] <= 1'b0;
      else vld[i+1] <= vld[i];
      if (r2 >= {2'b0, dv[i]}) begin
        rem[i+1] <= (QW+3)'(r2 - {2'b0, dv[i]});
        quo[i+1] <= {quo[i][NB-2:0], 1'b1};
      end else begin
        rem[i+1] <= (QW+3)'(r2);
        quo[i+1] <= {quo[i][NB-2:0], 1'b0};
      end
      dv[i+1]  <= dv[i];
      sd[i+1]  <= sd[i];
    end
  end

  assign out_valid = vld[NB];
  assign t         = (QW+1)'(quo[NB]);
  assign side_out  = sd[NB];
endmodule
`default_nettype wire

### rtl/normal_cdf_approximation.sv
// Top level of the normal CDF pipeline (A&S 7.1.26).
// Depends on ncdf_pkg and ncdf_div.
//
//  channel | signals              | direction
//  command | start, busy, x_value | in (busy is out)
//  result  | done, probability    | out
//
// One item per cycle; an accepted item passes in order through stages A and B,
// the 31-stage divider (numerator setup plus 30 quotient bits), stage C,
// 24 exp stages (two per Taylor step) and stages E and F, then done rises.
// busy is always low; sync reset clears all valid bits. The receiver cannot
// stall, so results leave on done exactly one cycle each.
`default_nettype none
module normal_cdf_approximation import ncdf_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic signed [X_W-1:0] x_value,
  output logic                       done,
  output logic [P_W-1:0]             probability
);
  localparam int NK = 12;

  assign busy = 1'b0;

  // stage A: magnitude, z, sign
  logic           a_v, a_neg;
  logic [QW-1:0]  a_z;
  always_ff @(posedge clk) begin
    logic [X_W:0]  mag;
    logic [63:0]   zp;
    mag = x_value[X_W-1] ? (X_W+1)'(-{x_value[X_W-1], x_value}) : (X_W+1)'(x_value);
    zp  = ({43'd0, mag} * {32'd0, K_INVSQRT2} + (64'd1 << (IN_FRAC_BITS - 1)))
          >> IN_FRAC_BITS;
    if (rst) a_v <= 1'b0;
    else a_v <= start;
    a_neg <= x_value[X_W-1];
    a_z   <= (zp > 64'(ZMAX)) ? ZMAX : QW'(zp);
  end

  // stage B: d = ONE + P*z, w = z*z
  logic           b_v, b_neg;
  logic [QW+1:0]  b_d;
  logic [QW+7:0]  b_w;
  always_ff @(posedge clk) begin
    if (rst) b_v <= 1'b0;
    else b_v <= a_v;
    b_neg <= a_neg;
    b_d   <= (QW+2)'({8'd0, ONE} + umulq({8'd0, K_P}, {8'd0, a_z}));
    b_w   <= umulq({8'd0, a_z}, {8'd0, a_z});
  end

  // divider; side data carries w (sign rides on separate line below)
  logic           v_v;
  logic [QW:0]    v_t;
  logic [QW+7:0]  v_w;
  ncdf_div u_div (.clk, .rst, .in_valid(b_v), .d(b_d), .side_in(b_w),
                  .out_valid(v_v), .t(v_t), .side_out(v_w));
  logic [30:0] neg_line;
  always_ff @(posedge clk) neg_line <= {neg_line[29:0], b_neg};
  // neg_line is as deep as the divider, so v_neg lines up with its output
  wire v_neg = neg_line[30];

  // stage C: split w into n = w div ln2 and r = w mod ln2
  logic           c_v, c_neg;
  logic [QW:0]    c_t;
  logic [6:0]     c_n;
  logic [QW+7:0]  c_r;
  always_ff @(posedge clk) begin
    logic [QW+7:0] r;
    logic [6:0]    n;
    r = v_w;
    n = '0;
    // w <= 64*ONE so n < 93; subtract by binary steps of ln2
    for (int b = 6; b >= 0; b--) begin
      if (r >= (QW+8)'({8'd0, K_LN2} << b)) begin
        r = r - (QW+8)'({8'd0, K_LN2} << b);
        n = n | 7'(1 << b);
      end
    end
    if (rst) c_v <= 1'b0;
    else c_v <= v_v;
    c_neg <= v_neg;
    c_t <= v_t;
    c_n <= n;
    c_r <= r;
  end

  // Horner polynomial stages and Taylor exp stages run side by side
  logic                   h_v [NK+1];
  logic                   h_neg [NK+1];
  logic [QW:0]            h_t [NK+1];
  logic [6:0]             h_n [NK+1];
  logic [QW-1:0]          h_r [NK+1];
  logic [QW-1:0]          h_s [NK+1];
  logic signed [QW:0]     h_acc [NK+1];
  logic                   m_v [NK];
  logic                   m_neg [NK];
  logic [QW:0]            m_t [NK];
  logic [6:0]             m_n [NK];
  logic [QW-1:0]          m_r [NK];
  logic [QW-1:0]          m_p [NK];
  logic signed [QW:0]     m_acc [NK];
  always_comb begin
    h_v[0]   = c_v;
    h_neg[0] = c_neg;
    h_t[0]   = c_t;
    h_n[0]   = c_n;
    h_r[0]   = QW'(c_r);
    h_s[0]   = ONE;
    h_acc[0] = K_A5;
  end

  for (genvar i = 0; i < NK; i++) begin : g_h
    localparam int K = NK - i;
    localparam logic [QW:0] RK = (QW+1)'((64'd1 << 32) / K);

    // first half: truncated product r*s and, while coefficients remain, one Horner step
    always_ff @(posedge clk) begin
      logic [63:0]         pr;
      logic signed [QW:0]  a;
      pr = {32'd0, h_r[i]} * {32'd0, h_s[i]};
      a  = h_acc[i];
      case (i)
        0: a = smulq(a, QW'(h_t[i])) + K_A4;
        1: a = smulq(a, QW'(h_t[i])) + K_A3;
        2: a = smulq(a, QW'(h_t[i])) + K_A2;
        3: a = smulq(a, QW'(h_t[i])) + K_A1;
        4: a = smulq(a, QW'(h_t[i]));
        default: a = a;
      endcase
      if (rst) m_v[i] <= 1'b0;
      else m_v[i] <= h_v[i];
      m_neg[i] <= h_neg[i];
      m_t[i]   <= h_t[i];
      m_n[i]   <= h_n[i];
      m_r[i]   <= h_r[i];
      m_p[i]   <= QW'(pr >> FQ);
      m_acc[i] <= a;
    end

    // second half: floor divide by k via reciprocal estimate plus one correction
    always_ff @(posedge clk) begin
      logic [63:0]   qe;
      logic [QW-1:0] qd;
      logic [QW-1:0] rm;
      qe = {32'd0, m_p[i]} * {31'd0, RK};
      qd = QW'(qe >> 32);
      rm = m_p[i] - QW'(qd * QW'(K));
      if (rm >= QW'(K)) qd = qd + 1'b1;
      if (rst) h_v[i+1] <= 1'b0;
      else h_v[i+1] <= m_v[i];
      h_neg[i+1] <= m_neg[i];
      h_t[i+1]   <= m_t[i];
      h_n[i+1]   <= m_n[i];
      h_r[i+1]   <= m_r[i];
      h_s[i+1]   <= ONE - qd;
      h_acc[i+1] <= m_acc[i];
    end
  end

  // stage E: clamp q, scale e by 2^-n
  logic           e_v, e_neg;
  logic [QW-1:0]  e_q, e_e;
  always_ff @(posedge clk) begin
    logic [QW-1:0] q;
    logic [QW:0]   rs;
    logic [6:0]    n;
    n = h_n[NK];
    if (h_acc[NK][QW]) q = '0;
    else if (h_acc[NK] > $signed({1'b0, ONE})) q = ONE;
    else q = QW'(h_acc[NK]);
    if (n >= 7'd40) rs = '0;
    else if (n == 7'd0) rs = {1'b0, h_s[NK]};
    else rs = ({1'b0, h_s[NK]} + ((QW+1)'(1) << (n - 7'd1))) >> n;
    if (rst) e_v <= 1'b0;
    else e_v <= h_v[NK];
    e_neg <= h_neg[NK];
    e_q <= q;
    e_e <= QW'(rs);
  end

  // stage F: c = q*e, halve, sign-select
  always_ff @(posedge clk) begin
    logic [QW+7:0] c;
    logic [QW+7:0] h;
    c = umulq({8'd0, e_q}, {8'd0, e_e});
    if (c > {8'd0, ONE}) c = {8'd0, ONE};
    h = (c + (QW+8)'(1 << (28 - OUT_FRAC_BITS))) >> (29 - OUT_FRAC_BITS);
    if (rst) done <= 1'b0;
    else done <= e_v;
    probability <= e_neg ? P_W'(h) : P_W'((1 << OUT_FRAC_BITS) - h);
  end

`ifndef ASSERT_OFF
  a_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");
  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> probability <= P_W'(1 << OUT_FRAC_BITS)) else $error("probability range");
  a_flow: assert property (@(posedge clk) disable iff (rst) e_v |=> done)
    else $error("lost result");
`endif
endmodule
`default_nettype wire

### test/ncdf_checker.sv
// Checker for normal_cdf_approximation: watches accepted x_value beats and
// done strobes, predicts Phi(x) in Q1.16 and compares. Depends on ncdf_pkg.
module ncdf_checker import ncdf_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic                  busy,
  input  wire logic signed [X_W-1:0] x_value,
  input  wire logic                  done,
  input  wire logic [P_W-1:0]        probability,
  output int                         fail_count,
  output int                         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned QONE = 64'd1 << 28;

  logic [P_W-1:0] cdf_queue[$];

  // Rounded Q.28 product of two unsigned values.
  function automatic longint unsigned qmul(longint unsigned a, longint unsigned b);
    return (a * b + (64'd1 << 27)) >> 28;
  endfunction

  // Signed by unsigned Q.28 product, rounded symmetrically.
  function automatic longint qmul_s(longint a, longint unsigned b);
    longint unsigned m;
    m = (a < 0) ? longint'(-a) : a;
    m = qmul(m, b);
    return (a < 0) ? -longint'(m) : longint'(m);
  endfunction

  // exp(-w) in Q.28 by range reduction on ln2 and a 12-term Horner series.
  function automatic longint unsigned exp_neg_q28(longint unsigned w);
    longint unsigned n, r, s;
    n = w / 64'(K_LN2);
    r = w % 64'(K_LN2);
    s = QONE;
    if (n >= 40) return 0;
    for (int k = 12; k >= 1; k--) s = QONE - ((r * s) >> 28) / k;
    if (n == 0) return s;
    return (s + (64'd1 << (n - 1))) >> n;
  endfunction

  function automatic logic [P_W-1:0] normal_cdf(logic signed [X_W-1:0] x);
    longint unsigned mag, z, d, t, q, e, c, h, res;
    longint acc;
    logic neg;
    neg = x[X_W-1];
    mag = neg ? ((64'd1 << X_W) - 64'(unsigned'(x))) : 64'(unsigned'(x));
    z = (mag * 64'(K_INVSQRT2) + (64'd1 << (IN_FRAC_BITS - 1))) >> IN_FRAC_BITS;
    if (z > 8 * QONE) z = 8 * QONE;
    d = QONE + qmul(64'(K_P), z);
    t = ((64'd1 << 56) + (d >> 1)) / d;
    // Horner evaluation of the erfc polynomial
    acc = 64'(K_A5);
    acc = qmul_s(acc, t) + 64'(K_A4);
    acc = qmul_s(acc, t) + 64'(K_A3);
    acc = qmul_s(acc, t) + 64'(K_A2);
    acc = qmul_s(acc, t) + 64'(K_A1);
    acc = qmul_s(acc, t);
    if (acc < 0) acc = 0;
    q = acc;
    if (q > QONE) q = QONE;
    e = exp_neg_q28(qmul(z, z));
    c = qmul(q, e);
    if (c > QONE) c = QONE;
    h = (c + (64'd1 << (28 - OUT_FRAC_BITS))) >> (29 - OUT_FRAC_BITS);
    res = neg ? h : ((64'd1 << OUT_FRAC_BITS) - h);
    if (res > (64'd1 << OUT_FRAC_BITS)) res = 64'd1 << OUT_FRAC_BITS;
    return P_W'(res);
  endfunction

  // Predict on each accepted beat, compare on each done strobe.
  always @(posedge clk) begin
    if (rst) begin
      cdf_queue.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (done) begin
        if (cdf_queue.size() == 0) begin
          $display("%0t: unexpected result probability=%0d", $realtime, probability);
          fail_count <= fail_count + 1;
        end else begin
          if (probability !== cdf_queue[0]) begin
            $display("%0t: probability mismatch expected=%0d actual=%0d",
                     $realtime, cdf_queue[0], probability);
            fail_count <= fail_count + 1;
          end
          void'(cdf_queue.pop_front());
        end
      end
      if (start && !busy) cdf_queue.push_back(normal_cdf(x_value));
      pending <= cdf_queue.size();
    end
  end
endmodule

### test/tb_normal_cdf_approximation.sv
// Testbench top for normal_cdf_approximation: drives x_value beats, some with
// random gaps, and reports the verdict. Depends on ncdf_pkg, ncdf_checker and the RTL.
module tb_normal_cdf_approximation import ncdf_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 80;
  localparam longint CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic signed [X_W-1:0] x_value = '0;
  logic busy, done;
  logic [P_W-1:0] probability;
  int fail_count, pending;
  longint cycles = 0;

  always #5 clk = ~clk;

  normal_cdf_approximation u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .x_value(x_value), .done(done), .probability(probability)
  );

  ncdf_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .x_value(x_value),
    .done(done), .probability(probability), .fail_count(fail_count),
    .pending(pending)
  );

  // Abort on a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("normal_cdf_approximation test failed");
      $finish;
    end
  end

  // Hold x_value with start high until the beat is accepted.
  task automatic send_beat(logic signed [X_W-1:0] x, bit allow_idle);
    while (allow_idle && $urandom_range(99) < 27) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    x_value <= x;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic signed [X_W-1:0] random_x();
    case ($urandom_range(9))
      0: return X_W'($urandom);
      1, 2: return X_W'($urandom_range(131072)) - X_W'($urandom_range(131072));
      3: return X_W'($urandom_range(16)) - X_W'(8);
      default: return X_W'($urandom_range(524288)) - X_W'(262144);
    endcase
  endfunction

  logic signed [X_W-1:0] directed[$] = '{
    20'sh00000, 20'sh00001, -20'sh00001, 20'sh7FFFF, 20'sh80000, 20'sh80001,
    20'sh10000, -20'sh10000, 20'sh20000, -20'sh20000, 20'sh30000, -20'sh30000,
    20'sh58000, -20'sh58000, 20'sh5A828, -20'sh5A828, 20'sh60000, -20'sh60000,
    20'sh08000, -20'sh08000, 20'sh55555, 20'shAAAAA, 20'sh0FFFF
  };

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // Directed extremes, back to back.
    foreach (directed[i]) send_beat(directed[i], 1'b0);
    start <= 1'b0;
    // Drain fully once before the random part.
    while (pending != 0) @(negedge clk);
    for (int i = 0; i < 1250; i++) begin
      send_beat(random_x(), !(i >= 400 && i < 600));
    end
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
    if (fail_count == 0) begin
      $display("normal_cdf_approximation test passed");
    end else begin
      $display("normal_cdf_approximation test failed");
    end
    $finish;
  end
endmodule

### filelist.f
rtl/ncdf_pkg.sv
rtl/ncdf_div.sv
rtl/normal_cdf_approximation.sv
test/ncdf_checker.sv
test/tb_normal_cdf_approximation.sv
